>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define OTB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define OTB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/otb_pkg.sv
// ----------------------------------------------------------------------------
// otb_pkg
// Shared widths, command codes and interface structs of the Otsu binarizer.
// ----------------------------------------------------------------------------
package otb_pkg;

    localparam int MAX_PIXELS_LOG2 = 20;
    localparam int CNT_W  = MAX_PIXELS_LOG2 + 1;   // bin count / pixel total
    localparam int SUM_W  = CNT_W + 8;             // gray-level sums
    localparam int PROD_W = SUM_W + CNT_W;         // s1*N, S*n1, |D|
    localparam int PQ_W   = 2 * CNT_W;             // n1*n2
    localparam int SQ_W   = 2 * PROD_W;            // D*D

    localparam int BINS     = 256;
    localparam int BIN_AW   = 8;
    localparam int LAST_BIN = BINS - 2;            // scan reads bins 0..254

    localparam int LIMB_W  = 32;
    localparam int MUL_A_W = 4 * LIMB_W;
    localparam int MUL_B_W = 2 * LIMB_W;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [7:0] PIX_BLACK = 8'd0;
    localparam logic [7:0] PIX_WHITE = 8'd255;

    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef enum logic [1:0] {
        CMD_ACCUM    = 2'd0,
        CMD_FINISH   = 2'd1,
        CMD_CLASSIFY = 2'd2,
        CMD_NONE     = 2'd3
    } cmd_t;

    typedef struct packed {
        logic              rd_en;
        logic [BIN_AW-1:0] rd_addr;
        logic              wr_en;
        logic [BIN_AW-1:0] wr_addr;
        logic [CNT_W-1:0]  wr_data;
        logic              clear;
    } hist_req_t;

    typedef struct packed {
        logic               start;
        logic [2:0]         na;     // A limbs, 1..4
        logic [1:0]         nb;     // B limbs, 1..2
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic       done;
        logic [7:0] thr;
    } scan_res_t;

    function automatic mul_req_t mul_cmd(logic [2:0] na, logic [1:0] nb,
                                         logic [MUL_A_W-1:0] a,
                                         logic [MUL_B_W-1:0] b);
        mul_req_t r;
        r.start = 1'b1;
        r.na    = na;
        r.nb    = nb;
        r.a     = a;
        r.b     = b;
        return r;
    endfunction

endpackage

>>> hw/rtl/otb_hist.sv
// ----------------------------------------------------------------------------
// otb_hist
// 256-bin histogram RAM, registered read, per-bin valid bits.
// ----------------------------------------------------------------------------
module otb_hist
    import otb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  hist_req_t        req,
    output logic [CNT_W-1:0] rd_data
);

    logic [CNT_W-1:0] mem [BINS];
    logic [BINS-1:0]  valid_reg;
    logic [CNT_W-1:0] rd_q_reg;
    logic             rd_v_reg;

    // invalid bin reads as zero
    assign rd_data = rd_v_reg ? rd_q_reg : '0;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_q_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_v_reg  <= 1'b0;
        end
        else
        begin
            if (req.clear)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_v_reg <= valid_reg[req.rd_addr];
            end
        end
    end

endmodule

>>> hw/rtl/otb_mul.sv
// ----------------------------------------------------------------------------
// otb_mul
// Limb-serial multiplier: one 32x32 partial product per cycle, 192-bit sum.
// ----------------------------------------------------------------------------
module otb_mul
    import otb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  mul_req_t           req,
    output logic               done,
    output logic [MUL_P_W-1:0] product
);

    logic [MUL_A_W-1:0]  a_reg;
    logic [MUL_B_W-1:0]  b_reg;
    logic [MUL_P_W-1:0]  acc_reg;
    logic [2*LIMB_W-1:0] p_reg;
    logic [2:0]          pos_reg;
    logic [1:0]          i_reg;
    logic                j_reg;
    logic [2:0]          na_reg;
    logic [1:0]          nb_reg;
    logic                run_reg;
    logic                pv_reg;
    logic                last_reg;
    logic                done_reg;
    logic                i_end;
    logic                j_end;
    logic [MUL_P_W-1:0]  p_shift;

    assign i_end   = ({1'b0, i_reg} == (na_reg - 3'd1));
    assign j_end   = ({1'b0, j_reg} == (nb_reg - 2'd1));
    assign p_shift = {{(MUL_P_W - 2*LIMB_W){1'b0}}, p_reg} << (LIMB_W * pos_reg);
    assign done    = done_reg;
    assign product = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            pv_reg   <= 1'b0;
            last_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
            j_reg    <= 1'b0;
            na_reg   <= 3'd1;
            nb_reg   <= 2'd1;
        end
        else if (req.start)
        begin
            run_reg  <= 1'b1;
            pv_reg   <= 1'b0;
            last_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
            j_reg    <= 1'b0;
            na_reg   <= req.na;
            nb_reg   <= req.nb;
        end
        else
        begin
            pv_reg   <= run_reg;
            last_reg <= run_reg && i_end && j_end;
            done_reg <= pv_reg && last_reg;
            if (run_reg)
            begin
                if (j_end)
                begin
                    j_reg <= 1'b0;
                    if (i_end)
                    begin
                        run_reg <= 1'b0;
                    end
                    else
                    begin
                        i_reg <= i_reg + 2'd1;
                    end
                end
                else
                begin
                    j_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= '0;
        end
        else
        begin
            if (run_reg)
            begin
                p_reg   <= a_reg[i_reg*LIMB_W +: LIMB_W] * b_reg[j_reg*LIMB_W +: LIMB_W];
                pos_reg <= {1'b0, i_reg} + {2'b00, j_reg};
            end
            if (pv_reg)
            begin
                acc_reg <= acc_reg + p_shift;
            end
        end
    end

endmodule

>>> hw/rtl/otb_scan.sv
// ----------------------------------------------------------------------------
// otb_scan
// Threshold search: walks the bins, forms D, compares D^2/(n1 n2) exactly.
// ----------------------------------------------------------------------------
module otb_scan
    import otb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [CNT_W-1:0]   n_total,
    input  logic [SUM_W-1:0]   s_total,
    input  logic [CNT_W-1:0]   bin_data,
    output logic               rd_en,
    output logic [BIN_AW-1:0]  rd_addr,
    output mul_req_t           mreq,
    input  logic               mul_done,
    input  logic [MUL_P_W-1:0] mul_product,
    output scan_res_t          res
);

    typedef enum logic [3:0] {
        SC_IDLE, SC_READ, SC_ACC, SC_CHK, SC_MA, SC_MB,
        SC_MPQ, SC_MDSQ, SC_ML, SC_MR, SC_NEXT
    } sc_state_t;

    sc_state_t          state_reg;
    logic [BIN_AW-1:0]  k_reg;
    logic [CNT_W-1:0]   n1_reg;
    logic [SUM_W-1:0]   s1_reg;
    logic [PROD_W-1:0]  a_reg;
    logic [PROD_W-1:0]  d_reg;
    logic [PQ_W-1:0]    pq_reg;
    logic [SQ_W-1:0]    dsq_reg;
    logic [MUL_P_W-1:0] lhs_reg;
    logic [SQ_W-1:0]    best_dsq_reg;
    logic [PQ_W-1:0]    best_pq_reg;
    logic [7:0]         best_t_reg;
    logic               have_best_reg;
    logic               done_reg;
    mul_req_t           mreq_reg;
    logic [CNT_W-1:0]   n2;
    logic [PROD_W-1:0]  b_now;

    assign n2       = n_total - n1_reg;
    assign b_now    = mul_product[PROD_W-1:0];
    assign rd_en    = (state_reg == SC_READ);
    assign rd_addr  = k_reg;
    assign mreq     = mreq_reg;
    assign res.done = done_reg;
    assign res.thr  = best_t_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SC_IDLE;
            k_reg         <= '0;
            n1_reg        <= '0;
            s1_reg        <= '0;
            a_reg         <= '0;
            d_reg         <= '0;
            pq_reg        <= '0;
            dsq_reg       <= '0;
            lhs_reg       <= '0;
            best_dsq_reg  <= '0;
            best_pq_reg   <= '0;
            best_t_reg    <= '0;
            have_best_reg <= 1'b0;
            done_reg      <= 1'b0;
            mreq_reg      <= '0;
        end
        else
        begin
            mreq_reg.start <= 1'b0;
            done_reg       <= 1'b0;
            case (state_reg)
                SC_IDLE:
                begin
                    if (start)
                    begin
                        k_reg         <= '0;
                        n1_reg        <= '0;
                        s1_reg        <= '0;
                        best_t_reg    <= '0;
                        have_best_reg <= 1'b0;
                        state_reg     <= SC_READ;
                    end
                end
                SC_READ:
                begin
                    state_reg <= SC_ACC;
                end
                SC_ACC:
                begin
                    n1_reg    <= n1_reg + bin_data;
                    s1_reg    <= s1_reg + SUM_W'(bin_data) * SUM_W'(k_reg);
                    state_reg <= SC_CHK;
                end
                SC_CHK:
                begin
                    // empty class: skip
                    if ((n1_reg == '0) || (n2 == '0))
                    begin
                        state_reg <= SC_NEXT;
                    end
                    else
                    begin
                        mreq_reg  <= mul_cmd(3'd2, 2'd1, MUL_A_W'(s1_reg),
                                             MUL_B_W'(n_total));
                        state_reg <= SC_MA;
                    end
                end
                SC_MA:
                begin
                    if (mul_done)
                    begin
                        a_reg     <= mul_product[PROD_W-1:0];
                        mreq_reg  <= mul_cmd(3'd2, 2'd1, MUL_A_W'(s_total),
                                             MUL_B_W'(n1_reg));
                        state_reg <= SC_MB;
                    end
                end
                SC_MB:
                begin
                    if (mul_done)
                    begin
                        // zero variance never wins
                        if (a_reg == b_now)
                        begin
                            state_reg <= SC_NEXT;
                        end
                        else
                        begin
                            d_reg     <= (a_reg > b_now) ? a_reg - b_now : b_now - a_reg;
                            mreq_reg  <= mul_cmd(3'd1, 2'd1, MUL_A_W'(n1_reg),
                                                 MUL_B_W'(n2));
                            state_reg <= SC_MPQ;
                        end
                    end
                end
                SC_MPQ:
                begin
                    if (mul_done)
                    begin
                        pq_reg    <= mul_product[PQ_W-1:0];
                        mreq_reg  <= mul_cmd(3'd2, 2'd2, MUL_A_W'(d_reg),
                                             MUL_B_W'(d_reg));
                        state_reg <= SC_MDSQ;
                    end
                end
                SC_MDSQ:
                begin
                    if (mul_done)
                    begin
                        dsq_reg <= mul_product[SQ_W-1:0];
                        if (!have_best_reg)
                        begin
                            best_dsq_reg  <= mul_product[SQ_W-1:0];
                            best_pq_reg   <= pq_reg;
                            best_t_reg    <= k_reg + 8'd1;
                            have_best_reg <= 1'b1;
                            state_reg     <= SC_NEXT;
                        end
                        else
                        begin
                            mreq_reg  <= mul_cmd(3'd4, 2'd2,
                                                 MUL_A_W'(mul_product[SQ_W-1:0]),
                                                 MUL_B_W'(best_pq_reg));
                            state_reg <= SC_ML;
                        end
                    end
                end
                SC_ML:
                begin
                    if (mul_done)
                    begin
                        lhs_reg   <= mul_product;
                        mreq_reg  <= mul_cmd(3'd4, 2'd2, MUL_A_W'(best_dsq_reg),
                                             MUL_B_W'(pq_reg));
                        state_reg <= SC_MR;
                    end
                end
                SC_MR:
                begin
                    if (mul_done)
                    begin
                        // strictly greater: first maximum stays
                        if (lhs_reg > mul_product)
                        begin
                            best_dsq_reg <= dsq_reg;
                            best_pq_reg  <= pq_reg;
                            best_t_reg   <= k_reg + 8'd1;
                        end
                        state_reg <= SC_NEXT;
                    end
                end
                SC_NEXT:
                begin
                    if (k_reg == BIN_AW'(LAST_BIN))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= SC_IDLE;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 8'd1;
                        state_reg <= SC_READ;
                    end
                end
                default:
                begin
                    state_reg <= SC_IDLE;
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/otsu_threshold_binarizer_top.sv
// ----------------------------------------------------------------------------
// otsu_threshold_binarizer_top
// 8-bit Otsu binarizer: histogram build, exact threshold search, classify.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                         Handshake
//  --------  --------------------------------------------  -----------------
//  request   start, busy, cmd, pixel                       start && !busy
//  result    result_valid, result_kind, binary_pixel,      one-cycle strobe
//            threshold, overflow
//
//  Classify: result in the cycle after the request; busy stays low, so
//  classify requests may come every cycle.
//  Accumulate: histogram read, then write back of count + 1.
//  Finish: paced per threshold by the limb-serial multiplier (up to six
//  products per threshold, none when a class is empty, up to 8 partial
//  products for each of the two cross products) over 255 thresholds;
//  report then clears the bins.
//  Reset: asynchronous, rst_n low; bins read as zero via valid bits, so
//  no clearing pass is needed. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module otsu_threshold_binarizer_top
    import otb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] cmd,
    input  logic [7:0] pixel,
    output logic       result_valid,
    output logic       result_kind,
    output logic [7:0] binary_pixel,
    output logic [7:0] threshold,
    output logic       overflow
);

    typedef enum logic [1:0] {ST_IDLE, ST_ACC_WR, ST_SCAN} st_t;

    st_t              state_reg;
    logic [CNT_W-1:0] total_reg;      // pixels in the current frame
    logic [SUM_W-1:0] sum_reg;        // sum of gray levels
    logic             dropped_reg;
    logic [7:0]       thr_reg;        // latched threshold
    logic [7:0]       pix_reg;
    logic             rv_reg;
    logic             kind_reg;
    logic [7:0]       bpix_reg;
    logic [7:0]       othr_reg;
    logic             ovf_reg;

    logic             accept;
    logic             full;
    hist_req_t        hreq;
    logic [CNT_W-1:0] bin_data;
    logic             scan_rd_en;
    logic [BIN_AW-1:0] scan_rd_addr;
    mul_req_t         mreq;
    logic             mul_done;
    logic [MUL_P_W-1:0] mul_product;
    scan_res_t        sres;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    // frame capacity reached: further pixels are dropped
    assign full   = (total_reg == (CNT_W'(1) << MAX_PIXELS_LOG2));

    assign result_valid = rv_reg;
    assign result_kind  = kind_reg;
    assign binary_pixel = bpix_reg;
    assign threshold    = othr_reg;
    assign overflow     = ovf_reg;

    // histogram port arbitration: accumulate RMW, or scan reads and the clear at scan end
    always_comb
    begin
        hreq = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd_t'(cmd) == CMD_ACCUM) && !full)
                begin
                    hreq.rd_en   = 1'b1;
                    hreq.rd_addr = pixel;
                end
            end
            ST_ACC_WR:
            begin
                hreq.wr_en   = 1'b1;
                hreq.wr_addr = pix_reg;
                hreq.wr_data = bin_data + CNT_W'(1);
            end
            ST_SCAN:
            begin
                hreq.rd_en   = scan_rd_en;
                hreq.rd_addr = scan_rd_addr;
                hreq.clear   = sres.done;
            end
            default:
            begin
                hreq = '0;
            end
        endcase
    end

    otb_hist u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (hreq),
        .rd_data (bin_data)
    );

    otb_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mreq),
        .done    (mul_done),
        .product (mul_product)
    );

    otb_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (accept && (cmd_t'(cmd) == CMD_FINISH)),
        .n_total     (total_reg),
        .s_total     (sum_reg),
        .bin_data    (bin_data),
        .rd_en       (scan_rd_en),
        .rd_addr     (scan_rd_addr),
        .mreq        (mreq),
        .mul_done    (mul_done),
        .mul_product (mul_product),
        .res         (sres)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            total_reg   <= '0;
            sum_reg     <= '0;
            dropped_reg <= 1'b0;
            thr_reg     <= '0;
            pix_reg     <= '0;
            rv_reg      <= 1'b0;
            kind_reg    <= KIND_PIXEL;
            bpix_reg    <= '0;
            othr_reg    <= '0;
            ovf_reg     <= 1'b0;
        end
        else
        begin
            rv_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (cmd_t'(cmd))
                            CMD_ACCUM:
                            begin
                                if (full)
                                begin
                                    dropped_reg <= 1'b1;
                                end
                                else
                                begin
                                    pix_reg   <= pixel;
                                    total_reg <= total_reg + CNT_W'(1);
                                    sum_reg   <= sum_reg + SUM_W'(pixel);
                                    state_reg <= ST_ACC_WR;
                                end
                            end
                            CMD_FINISH:
                            begin
                                state_reg <= ST_SCAN;
                            end
                            CMD_CLASSIFY:
                            begin
                                rv_reg   <= 1'b1;
                                kind_reg <= KIND_PIXEL;
                                bpix_reg <= (pixel < thr_reg) ? PIX_BLACK : PIX_WHITE;
                                othr_reg <= thr_reg;
                                ovf_reg  <= dropped_reg;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;   // unused code: ignored
                            end
                        endcase
                    end
                end
                ST_ACC_WR:
                begin
                    state_reg <= ST_IDLE;
                end
                ST_SCAN:
                begin
                    if (sres.done)
                    begin
                        // report, latch, start a fresh frame
                        rv_reg      <= 1'b1;
                        kind_reg    <= KIND_REPORT;
                        bpix_reg    <= PIX_BLACK;
                        othr_reg    <= sres.thr;
                        ovf_reg     <= dropped_reg;
                        thr_reg     <= sres.thr;
                        total_reg   <= '0;
                        sum_reg     <= '0;
                        dropped_reg <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/otb_chk.sv
// ----------------------------------------------------------------------------
// otb_chk
// Port-level checks of the Otsu binarizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module otb_chk
    import otb_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] cmd,
    input logic [7:0] pixel,
    input logic       result_valid,
    input logic       result_kind,
    input logic [7:0] binary_pixel,
    input logic [7:0] threshold,
    input logic       overflow
);

    `OTB_ASSERT_NEXT(a_cls_result, start && !busy && (cmd == CMD_CLASSIFY), result_valid && (result_kind == KIND_PIXEL), "classify request gave no pixel result")
    `OTB_ASSERT_NEXT(a_acc_silent, start && !busy && (cmd == CMD_ACCUM), !result_valid, "accumulate request gave a result")
    `OTB_ASSERT_SAME(a_rep_zero, result_valid && (result_kind == KIND_REPORT), binary_pixel == PIX_BLACK, "report carries nonzero pixel")
    `OTB_ASSERT_SAME(a_rep_idle, result_valid && (result_kind == KIND_REPORT), !busy, "block still busy while reporting")

endmodule

bind otsu_threshold_binarizer_top otb_chk u_otb_chk (.*);

>>> tb/otsu_checker.sv
// ----------------------------------------------------------------------------
// otsu_checker
// Watches the request and result channels of the Otsu binarizer, predicts
// each result from its own histogram and threshold search, and counts
// mismatches.
// ----------------------------------------------------------------------------
module otsu_checker
    import otb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic [1:0] cmd,
    input  logic [7:0] pixel,
    input  logic       result_valid,
    input  logic       result_kind,
    input  logic [7:0] binary_pixel,
    input  logic [7:0] threshold,
    input  logic       overflow,
    output int         fail_count,
    output int         pending
);

    typedef struct packed {
        logic       kind;
        logic [7:0] bin_pix;
        logic [7:0] thr;
        logic       ovf;
    } otsu_result_t;

    otsu_result_t     want_q[$];
    logic [CNT_W-1:0] hist [BINS];
    logic [CNT_W-1:0] frame_pixels;
    logic             frame_dropped;
    logic [7:0]       cur_thr;

    // Exact search: compare d^2/(n1 n2) by cross multiplication.
    function automatic logic [7:0] otsu_pick();
        logic [63:0]  n_all, s_all, n1, s1, n2, a, b;
        logic [191:0] d, best_d, best_pq, pq, lhs, rhs;
        logic         have_best;
        logic [7:0]   best_t;
        n_all = 0; s_all = 0; n1 = 0; s1 = 0;
        best_d = 0; best_pq = 0; have_best = 0; best_t = 0;
        for (int k = 0; k < BINS; k++)
        begin
            n_all += hist[k];
            s_all += 64'(hist[k]) * k;
        end
        for (int t = 1; t < BINS; t++)
        begin
            n1 += hist[t-1];
            s1 += 64'(hist[t-1]) * (t - 1);
            n2 = n_all - n1;
            if (n1 == 0 || n2 == 0)
                continue;
            a = s1 * n_all;
            b = s_all * n1;
            d = (a > b) ? 192'(a - b) : 192'(b - a);
            if (d == 0)
                continue;
            pq = 192'(n1 * n2);
            if (have_best)
            begin
                lhs = d * d * best_pq;
                rhs = best_d * best_d * pq;
                if (!(lhs > rhs))
                    continue;
            end
            have_best = 1;
            best_d    = d;
            best_pq   = pq;
            best_t    = t[7:0];
        end
        return best_t;
    endfunction

    assign pending = want_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        otsu_result_t got, want;
        if (!rst_n)
        begin
            want_q.delete();
            foreach (hist[i]) hist[i] = '0;
            frame_pixels  = '0;
            frame_dropped = 1'b0;
            cur_thr       = '0;
            fail_count    = 0;
        end
        else
        begin
            // results first: a result never belongs to a request of this edge
            if (result_valid)
            begin
                got = '{result_kind, binary_pixel, threshold, overflow};
                if (want_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("checker: unexpected result %p", got);
                end
                else
                begin
                    want = want_q.pop_front();
                    if (got != want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("checker: mismatch exp %p got %p", want, got);
                    end
                end
            end
            if (start && !busy)
            begin
                case (cmd_t'(cmd))
                    CMD_ACCUM:
                        if (frame_pixels < (1 << MAX_PIXELS_LOG2))
                        begin
                            hist[pixel]++;
                            frame_pixels++;
                        end
                        else
                            frame_dropped = 1'b1;
                    CMD_FINISH:
                    begin
                        cur_thr = otsu_pick();
                        want_q.push_back('{KIND_REPORT, PIX_BLACK, cur_thr, frame_dropped});
                        foreach (hist[i]) hist[i] = '0;
                        frame_pixels  = '0;
                        frame_dropped = 1'b0;
                    end
                    CMD_CLASSIFY:
                        want_q.push_back('{KIND_PIXEL,
                                           (pixel < cur_thr) ? PIX_BLACK : PIX_WHITE,
                                           cur_thr, frame_dropped});
                    default: ;
                endcase
            end
        end
    end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives accumulate, finish and classify requests into the Otsu binarizer:
// a directed opening, then random frames. The checker predicts and
// compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import otb_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [1:0] cmd;
    logic [7:0] pixel;
    logic       result_valid;
    logic       result_kind;
    logic [7:0] binary_pixel;
    logic [7:0] threshold;
    logic       overflow;
    int         fail_count;
    int         pending;
    int         idle_pct;   // chance in percent of a gap before a request

    otsu_threshold_binarizer_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_kind  (result_kind),
        .binary_pixel (binary_pixel),
        .threshold    (threshold),
        .overflow     (overflow)
    );

    otsu_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_kind  (result_kind),
        .binary_pixel (binary_pixel),
        .threshold    (threshold),
        .overflow     (overflow),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Issue one request and return at the edge that accepts it. start is
    // left high so back-to-back requests never toggle it within one step.
    task automatic issue(input cmd_t c, input logic [7:0] p);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        pixel <= p;
        do
            @(posedge clk);
        while (busy);
    endtask

    // One frame of n pixels, uniform or drawn around one or two gray-level clusters.
    task automatic random_frame(input int n);
        logic [7:0] lo_c, hi_c;
        int         spread, mode;
        lo_c   = 8'($urandom_range(0, 255));
        hi_c   = 8'($urandom_range(0, 255));
        spread = $urandom_range(0, 40);
        mode   = $urandom_range(0, 3);
        for (int i = 0; i < n; i++)
        begin
            if (mode == 0)
                issue(CMD_ACCUM, 8'($urandom_range(0, 255)));
            else if (mode == 1)
                issue(CMD_ACCUM, lo_c);     // one level only: no winner
            else
                issue(CMD_ACCUM, 8'((($urandom_range(1) ? lo_c : hi_c)
                                     + $urandom_range(0, spread)) & 8'hff));
            if ($urandom_range(99) < 8)
                issue(CMD_CLASSIFY, 8'($urandom_range(0, 255)));
            if ($urandom_range(99) < 3)
                issue(CMD_NONE, 8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        start    = 1'b0;
        cmd      = CMD_ACCUM;
        pixel    = '0;
        idle_pct = 20;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset threshold, empty frame, single level, extremes
        issue(CMD_CLASSIFY, 8'd0);
        issue(CMD_CLASSIFY, 8'd255);
        issue(CMD_NONE, 8'hff);
        issue(CMD_FINISH, 8'd0);
        repeat (3) issue(CMD_ACCUM, 8'd77);
        issue(CMD_FINISH, 8'h00);
        repeat (2) issue(CMD_ACCUM, 8'd0);
        repeat (2) issue(CMD_ACCUM, 8'd255);
        issue(CMD_ACCUM, 8'd128);
        issue(CMD_FINISH, 8'h55);
        issue(CMD_CLASSIFY, 8'd0);
        issue(CMD_CLASSIFY, 8'd254);
        issue(CMD_CLASSIFY, 8'd255);
        issue(CMD_CLASSIFY, 8'haa);
        // symmetric three-level frame: equal variance ties, first one wins
        issue(CMD_ACCUM, 8'd10);
        issue(CMD_ACCUM, 8'd20);
        issue(CMD_ACCUM, 8'd30);
        issue(CMD_FINISH, 8'd0);
        issue(CMD_CLASSIFY, 8'd19);

        // random frames; the first stretch runs without gaps
        for (int f = 0; f < 60; f++)
        begin
            idle_pct = (f < 15) ? 0 : 20;
            random_frame(($urandom_range(99) < 5) ? 200 : $urandom_range(1, 20));
            repeat ($urandom_range(1, 3)) issue(CMD_CLASSIFY, 8'($urandom_range(0, 255)));
            issue(CMD_FINISH, 8'($urandom_range(0, 255)));
            issue(CMD_CLASSIFY, 8'($urandom_range(0, 255)));
        end

        start <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // about 65 finish scans in the whole run; this timeout ends a hung run
    initial
    begin
        #40000000;
        $display("testbench: errors");
        $finish;
    end

endmodule
